FILE: rtl/sbr_pkg.sv
// Shared types and constants for the sliding box blur row filter.
// No dependencies; compiled first.
package sbr_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int SUM_BITS       = SAMPLE_BITS + 6;
  localparam int NCH            = 3;
  localparam int RADIUS_BITS    = 5;
  localparam int RADIUS_MAX_DEF = 16;
  localparam int ROW_MAX_DEF    = 4096;

  localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = RADIUS_BITS'(2);

  // channel order inside a pixel word
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef sample_t [NCH-1:0]      sample_vec_t;
  typedef logic [SUM_BITS-1:0]    sum_t;
  typedef sum_t [NCH-1:0]         sum_vec_t;

  typedef struct packed {
    logic start;
    logic ack;
  } div_ctl_t;

endpackage

FILE: rtl/sbr_ifs.sv
// Valid/ready channel interfaces: pixel input, averaged output, radius write.
// Depends on sbr_pkg.
interface sbr_pix_in_if;
  import sbr_pkg::*;
  logic    valid;
  logic    ready;
  sample_t red_in;
  sample_t green_in;
  sample_t blue_in;
  logic    last_in_row;

  modport source (output valid, red_in, green_in, blue_in, last_in_row, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, last_in_row, output ready);
endinterface

interface sbr_pix_out_if;
  import sbr_pkg::*;
  logic    valid;
  logic    ready;
  sample_t red_out;
  sample_t green_out;
  sample_t blue_out;
  logic    row_end;

  modport source (output valid, red_out, green_out, blue_out, row_end, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, row_end, output ready);
endinterface

interface sbr_cfg_if;
  import sbr_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [RADIUS_BITS-1:0] radius;

  modport source (output valid, radius, input ready);
  modport sink   (input valid, radius, output ready);
endinterface

FILE: rtl/sbr_div.sv
// Three-lane restoring divider, one quotient bit per cycle, shared divisor.
// Quotients saturate to the sample range. Depends on sbr_pkg.
module sbr_div #(
  parameter int CW = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sbr_pkg::div_ctl_t  ctl,
  input  sbr_pkg::sum_vec_t  dividend,
  input  logic [CW-1:0]      divisor,
  output logic               done,
  output sbr_pkg::sample_vec_t quotient
);
  import sbr_pkg::*;

  localparam int NW = $clog2(SUM_BITS + 1);

  logic              run_r;
  logic [NW-1:0]     cnt_r;
  logic [CW-1:0]     dvs_r;
  sum_t              quo_r [NCH];
  logic [CW-1:0]     rem_r [NCH];
  logic [CW:0]       shifted [NCH];
  logic              qbit [NCH];

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      shifted[c] = {rem_r[c], quo_r[c][SUM_BITS-1]};
      qbit[c]    = shifted[c] >= {1'b0, dvs_r};
      quotient[c] = (|quo_r[c][SUM_BITS-1:SAMPLE_BITS]) ? '1 : quo_r[c][SAMPLE_BITS-1:0];
    end
  end

  assign done = run_r && (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (ctl.start) begin
      run_r <= 1'b1;
      cnt_r <= NW'(SUM_BITS);
    end else if (ctl.ack) begin
      run_r <= 1'b0;
    end else if (run_r && cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dvs_r <= divisor;
      for (int c = 0; c < NCH; c++) begin
        quo_r[c] <= dividend[c];
        rem_r[c] <= '0;
      end
    end else if (run_r && cnt_r != '0) begin
      for (int c = 0; c < NCH; c++) begin
        quo_r[c] <= {quo_r[c][SUM_BITS-2:0], qbit[c]};
        rem_r[c] <= qbit[c] ? CW'(shifted[c] - {1'b0, dvs_r}) : shifted[c][CW-1:0];
      end
    end
  end

endmodule

FILE: rtl/sliding_box_blur_row.sv
// Row box blur over a ring memory of past pixels; uses sbr_pkg, sbr_ifs, sbr_div.
// A pixel with a result goes through the read, apply and divide states, where
// the one-bit-per-cycle divider runs; a pixel with none skips the divide
// state. Each extra flushed result on a row's last pixel goes through read,
// apply and divide again. Pixel t's result is produced after input t+radius is taken.
// Sync reset clears sums, positions, radius (to 2), handshake; not the memory.
module sliding_box_blur_row #(
  parameter int RADIUS_MAX = sbr_pkg::RADIUS_MAX_DEF,
  parameter int ROW_MAX    = sbr_pkg::ROW_MAX_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  sbr_pix_in_if.sink    in_ch,
  sbr_pix_out_if.source out_ch,
  sbr_cfg_if.sink       cfg_ch
);
  import sbr_pkg::*;

  localparam int DEPTH = 2 * RADIUS_MAX + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(ROW_MAX);
  localparam int KW    = $clog2(RADIUS_MAX + 1);
  localparam int CW    = KW + 1;
  localparam int NW    = PW + KW + 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;
  localparam logic [1:0] S_DIV   = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [RADIUS_BITS-1:0] radius_r;
  logic [AW-1:0]          ring_r;
  logic [PW-1:0]          pos_r, pos_nxt;
  logic [KW-1:0]          k_r, k_nxt;
  sample_vec_t            item_r;
  logic                   last_r;
  sum_vec_t               sum_r, sum_nxt;
  sample_vec_t            rd_q;

  sample_vec_t            mem [DEPTH];

  logic                   out_valid_r;
  sample_vec_t            out_pix_r;
  logic                   out_end_r;

  logic [KW-1:0]          r_w;
  logic [CW-1:0]          span_w, age_w, count_w;
  logic [AW:0]            addr_sum;
  logic [AW-1:0]          rd_addr;
  logic [NW-1:0]          pk_w, p1_w;
  logic                   drop_w, emit_w, final_w;
  logic                   accept, out_free, load_out, step_done, mem_we;
  div_ctl_t               div_ctl;
  logic                   div_done;
  sample_vec_t            div_quo;

  assign in_ch.ready  = rst_n && (state_r == S_IDLE);
  assign cfg_ch.ready = rst_n;
  assign accept       = in_ch.valid && in_ch.ready;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.red_out   = out_pix_r[CH_RED];
  assign out_ch.green_out = out_pix_r[CH_GREEN];
  assign out_ch.blue_out  = out_pix_r[CH_BLUE];
  assign out_ch.row_end   = out_end_r;
  assign out_free         = !out_valid_r || out_ch.ready;

  // step k of an item: k = 0 is the pixel itself, 1..r are flush steps
  always_comb begin
    r_w      = (32'(radius_r) > RADIUS_MAX) ? KW'(RADIUS_MAX) : KW'(radius_r);
    span_w   = {r_w, 1'b1};
    age_w    = span_w - CW'(k_r);
    addr_sum = (AW + 1)'(ring_r) + (AW + 1)'(DEPTH) - (AW + 1)'(age_w);
    rd_addr  = (addr_sum >= (AW + 1)'(DEPTH)) ? AW'(addr_sum - (AW + 1)'(DEPTH))
                                              : addr_sum[AW-1:0];
    pk_w     = NW'(pos_r) + NW'(k_r);
    p1_w     = NW'(pos_r) + NW'(1);
    drop_w   = pk_w >= NW'(span_w);
    emit_w   = pk_w >= NW'(r_w);
    count_w  = (p1_w < NW'(age_w)) ? p1_w[CW-1:0] : age_w;
    final_w  = !last_r || (k_r == r_w);
  end

  assign mem_we   = (state_r == S_APPLY) && (k_r == '0);
  assign load_out = (state_r == S_DIV) && div_done && out_free;

  always_comb begin
    step_done = 1'b0;
    unique case (state_r)
      S_APPLY: step_done = !emit_w;
      S_DIV:   step_done = load_out;
      default: step_done = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_READ;
          k_nxt     = '0;
        end
      end
      S_READ: state_nxt = S_APPLY;
      S_APPLY: begin
        for (int c = 0; c < NCH; c++) begin
          sum_nxt[c] = sum_r[c] - (drop_w ? SUM_BITS'(rd_q[c]) : '0)
                     + ((k_r == '0) ? SUM_BITS'(item_r[c]) : '0);
        end
        if (emit_w) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: ;
      default: state_nxt = S_IDLE;
    endcase
    if (step_done) begin
      if (!final_w) begin
        k_nxt     = k_r + 1'b1;
        state_nxt = S_READ;
      end else begin
        state_nxt = S_IDLE;
        if (last_r) begin
          pos_nxt = '0;
          sum_nxt = '0;
        end else if (32'(pos_r) < ROW_MAX - 1) begin
          pos_nxt = pos_r + 1'b1;
        end
      end
    end
  end

  assign div_ctl.start = (state_r == S_APPLY) && emit_w;
  assign div_ctl.ack   = load_out;

  sbr_div #(.CW(CW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (sum_nxt),
    .divisor  (count_w),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      radius_r    <= RADIUS_RESET;
      ring_r      <= AW'(DEPTH - 1);
      pos_r       <= '0;
      k_r         <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      pos_r   <= pos_nxt;
      sum_r   <= sum_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        radius_r <= cfg_ch.radius;
      end
      if (accept) begin
        ring_r <= (ring_r == AW'(DEPTH - 1)) ? '0 : ring_r + 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r[CH_RED]   <= in_ch.red_in;
      item_r[CH_GREEN] <= in_ch.green_in;
      item_r[CH_BLUE]  <= in_ch.blue_in;
      last_r           <= in_ch.last_in_row;
    end
    if (load_out) begin
      out_pix_r <= div_quo;
      out_end_r <= last_r && (k_r == r_w);
    end
  end

  // window ring: read-first, so the oldest sample is seen before overwrite
  always_ff @(posedge clk) begin
    rd_q <= mem[rd_addr];
    if (mem_we) begin
      mem[ring_r] <= item_r;
    end
  end

endmodule
